// File: rtl/core/preemptive_priority_scheduler_macros.svh
// assertion macros used by the scheduler checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication, disabled during reset
`define PPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

// File: rtl/core/pps_pkg.sv
`default_nettype none

package pps_pkg;

   // one ready queue entry, prio in the top byte
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] burst;
      logic [7:0]  id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // result item, ran in bit 0
   typedef struct packed {
      logic        dropped;
      logic [31:0] wait_total;
      logic [4:0]  queued;
      logic        dispatched;
      logic [7:0]  run_id;
      logic        ran;
   } rsp_type;

   localparam int RSP_W    = $bits(rsp_type);
   localparam int QUEUED_W = 5;

   // item kinds carried on req_tuser
   localparam logic FUNC_ARRIVE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/pps_ram.sv
`default_nettype none

module pps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/preemptive_priority_scheduler.sv
// Preemptive priority scheduler over a ready queue sorted by priority.
// req channel: one item per handshake; req_tuser is the kind (0 arrival,
// 1 tick), req_tdata carries proc_id, burst and prio of an arrival.
// rsp channel: exactly one result item per request item, in order.
// The block takes one item at a time; req_tready is high only when idle.
// All queue work goes through one queue memory with one write port and a
// registered read and one shared index adder. The result is offered in the
// same cycle as the block is ready again. An arrival into an empty queue
// is written straight to the head; otherwise the walk reads from the tail
// and shifts each entry of lower priority up until it meets one of equal
// or higher priority or reaches the head. An arrival at a full queue is
// dropped, and a tick on an empty queue only reports. A tick removes each
// finished head entry and closes the gap behind it, then runs the head
// entry left, if any, for one unit.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result waits for the register to drain, so a stalled
// receiver only holds back the block at the end of the following item.
// Reset empties the queue, arms the dispatch flag, clears the waiting
// total and drops any result not yet taken. Queue contents are not cleared.
`default_nettype none

module preemptive_priority_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // proc_id[7:0], burst[23:8], prio[31:24]
   input  wire logic        req_tuser,  // func[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata   // ran, run_id, dispatched, queued,
                                        // wait_total, dropped
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_RD   = 4'd1;
   localparam logic [3:0] S_INS_CHK  = 4'd2;
   localparam logic [3:0] S_INS_PUT  = 4'd3;
   localparam logic [3:0] S_HEAD_RD  = 4'd4;
   localparam logic [3:0] S_HEAD_CHK = 4'd5;
   localparam logic [3:0] S_POP_RD   = 4'd6;
   localparam logic [3:0] S_POP_WR   = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pending_ff, pending_in;
   logic [31:0]         wsum_ff, wsum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pps_pkg::entry_type  new_ff, new_in;
   logic                res_ran_ff, res_ran_in;
   logic [7:0]          res_id_ff, res_id_in;
   logic                res_disp_ff, res_disp_in;
   logic                res_drop_ff, res_drop_in;
   pps_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                step_dec;
   logic [CNT_W-1:0]    idx_step;
   logic [CNT_W-1:0]    cnt_m1;
   logic [32:0]         sum_wide;
   logic [31:0]         wsum_sat;
   logic [CNT_W+4:0]    cnt_ext;
   logic                req_fire;
   logic                out_free;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [pps_pkg::ENTRY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]             rd_addr;
   logic [pps_pkg::ENTRY_W-1:0]   rd_data;
   pps_pkg::entry_type            rd_entry;
   pps_pkg::entry_type            run_entry;

   // ready queue storage, head at address 0
   pps_ram #(
      .WIDTH (pps_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared index adder: walks down while inserting, up while removing
   assign step_dec = (state_ff == S_INS_RD) || (state_ff == S_INS_CHK);
   assign idx_step = step_dec ? (idx_ff - CNT_W'(1)) : (idx_ff + CNT_W'(1));
   assign cnt_m1   = cnt_ff - CNT_W'(1);

   // saturating waiting total
   assign sum_wide = {1'b0, wsum_ff} + 33'(cnt_m1);
   assign wsum_sat = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

   assign cnt_ext  = {5'd0, cnt_ff};
   assign rd_entry = pps_pkg::entry_type'(rd_data);

   // head entry after running one unit
   always_comb begin
      run_entry       = rd_entry;
      run_entry.burst = rd_entry.burst - 16'd1;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // queue read address
   always_comb begin
      case (state_ff)
         S_INS_RD: rd_addr = idx_step[ADDR_W-1:0];
         S_POP_RD: rd_addr = idx_step[ADDR_W-1:0];
         default:  rd_addr = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pending_in   = pending_ff;
      wsum_in      = wsum_ff;
      new_in       = new_ff;
      res_ran_in   = res_ran_ff;
      res_id_in    = res_id_ff;
      res_disp_in  = res_disp_ff;
      res_drop_in  = res_drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               new_in      = pps_pkg::entry_type'(req_tdata);
               res_ran_in  = 1'b0;
               res_id_in   = 8'd0;
               res_disp_in = 1'b0;
               res_drop_in = 1'b0;
               if (req_tuser == pps_pkg::FUNC_ARRIVE) begin
                  if (cnt_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     res_drop_in = 1'b1;
                     state_in    = S_DONE;
                  end else if (cnt_ff == '0) begin
                     idx_in   = '0;
                     state_in = S_INS_PUT;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = S_INS_RD;
                  end
               end else begin
                  state_in = (cnt_ff == '0) ? S_DONE : S_HEAD_RD;
               end
            end
         end
         S_INS_RD: begin
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            // stop behind an entry of equal or higher priority, else shift it up
            if (rd_entry.prio >= new_ff.prio) begin
               state_in = S_INS_PUT;
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[ADDR_W-1:0];
               wr_data = rd_data;
               idx_in  = idx_step;
               state_in = (idx_step == '0) ? S_INS_PUT : S_INS_RD;
            end
         end
         S_INS_PUT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_data = new_ff;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (idx_ff == '0) begin
               pending_in = 1'b1;
            end
            state_in = S_DONE;
         end
         S_HEAD_RD: begin
            state_in = S_HEAD_CHK;
         end
         S_HEAD_CHK: begin
            if (rd_entry.burst == 16'd0) begin
               // finished head: drop it and close the gap
               cnt_in     = cnt_m1;
               pending_in = 1'b1;
               idx_in     = '0;
               state_in   = (cnt_m1 == '0) ? S_DONE : S_POP_RD;
            end else begin
               wr_en       = 1'b1;
               wr_addr     = '0;
               wr_data     = run_entry;
               res_ran_in  = 1'b1;
               res_id_in   = rd_entry.id;
               res_disp_in = pending_ff;
               pending_in  = 1'b0;
               wsum_in     = wsum_sat;
               state_in    = S_DONE;
            end
         end
         S_POP_RD: begin
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_data = rd_data;
            idx_in  = idx_step;
            state_in = (idx_step == cnt_ff) ? S_HEAD_RD : S_POP_RD;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_data_in.ran        = res_ran_ff;
               rsp_data_in.run_id     = res_id_ff;
               rsp_data_in.dispatched = res_disp_ff;
               rsp_data_in.queued     = cnt_ext[pps_pkg::QUEUED_W-1:0];
               rsp_data_in.wait_total = wsum_ff;
               rsp_data_in.dropped    = res_drop_ff;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pending_ff   <= 1'b1;
         wsum_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pending_ff   <= pending_in;
         wsum_ff      <= wsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk index
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      res_ran_ff  <= res_ran_in;
      res_id_ff   <= res_id_in;
      res_disp_ff <= res_disp_in;
      res_drop_ff <= res_drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/pps_checker.sv
`default_nettype none

`include "preemptive_priority_scheduler_macros.svh"

module pps_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   pps_pkg::rsp_type rsp;
   logic             req_fire;

   assign rsp      = pps_pkg::rsp_type'(rsp_tdata);
   assign req_fire = req_tvalid && req_tready;

   // a stalled result stays offered
   `PPS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // one item at a time: busy right after an item is taken
   `PPS_ASSERT_NXT(a_busy_after_take, clock, reset, req_fire, !req_tready)

   // a refused arrival never reports a run
   `PPS_ASSERT_IMP(a_drop_no_run, clock, reset, rsp_tvalid && rsp.dropped, !rsp.ran)

   // no run means no id and no dispatch
   `PPS_ASSERT_IMP(a_idle_fields, clock, reset, rsp_tvalid && !rsp.ran,
                   !rsp.dispatched && (rsp.run_id == 8'd0))

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

`default_nettype wire

// File: test/tb_preemptive_priority_scheduler.sv
module tb_preemptive_priority_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 725;

   // one request item as offered to the scheduler
   typedef struct {
      logic        func;
      logic [7:0]  proc_id;
      logic [15:0] burst;
      logic [7:0]  prio;
   } sched_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // proc_id[7:0], burst[23:8], prio[31:24]
   logic        req_tuser = 1'b0; // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // ran, run_id, dispatched, queued, wait_total, dropped

   sched_item_type     sched_items[$];
   pps_pkg::rsp_type   results_due[$];
   int                 mismatch_count = 0;

   // shadow of the scheduler state
   pps_pkg::entry_type ready_shadow[$];
   logic               dispatch_armed = 1'b1;
   logic [31:0]        wait_sum = '0;

   preemptive_priority_scheduler #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the shadow scheduler by one item and return its result
   function automatic pps_pkg::rsp_type schedule_step(input sched_item_type it);
      pps_pkg::rsp_type   r;
      pps_pkg::entry_type slot;
      int                 pos;
      longint unsigned    sum;
      r = '0;
      if (it.func == pps_pkg::FUNC_ARRIVE) begin
         if (ready_shadow.size() >= QUEUE_DEPTH) begin
            r.dropped = 1'b1;
         end else begin
            pos = 0;
            while (pos < ready_shadow.size() && ready_shadow[pos].prio >= it.prio)
               pos++;
            slot.id    = it.proc_id;
            slot.burst = it.burst;
            slot.prio  = it.prio;
            ready_shadow.insert(pos, slot);
            if (pos == 0)
               dispatch_armed = 1'b1;
         end
      end else begin
         // finished entries leave the head before anything runs
         while (ready_shadow.size() > 0 && ready_shadow[0].burst == 16'd0) begin
            void'(ready_shadow.pop_front());
            dispatch_armed = 1'b1;
         end
         if (ready_shadow.size() > 0) begin
            slot = ready_shadow[0];
            r.ran        = 1'b1;
            r.run_id     = slot.id;
            r.dispatched = dispatch_armed;
            dispatch_armed = 1'b0;
            slot.burst = slot.burst - 16'd1;
            ready_shadow[0] = slot;
            sum = longint'(wait_sum) + longint'(ready_shadow.size() - 1);
            wait_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         end
      end
      r.queued     = 5'(ready_shadow.size());
      r.wait_total = wait_sum;
      return r;
   endfunction

   task automatic add_arrival(input logic [7:0] id, input logic [15:0] burst,
                              input logic [7:0] prio);
      sched_item_type it;
      it.func    = pps_pkg::FUNC_ARRIVE;
      it.proc_id = id;
      it.burst   = burst;
      it.prio    = prio;
      sched_items.push_back(it);
   endtask

   // tick with random junk in the unused data bits
   task automatic add_tick();
      sched_item_type it;
      it.func    = pps_pkg::FUNC_TICK;
      it.proc_id = 8'($urandom);
      it.burst   = 16'($urandom);
      it.prio    = 8'($urandom);
      sched_items.push_back(it);
   endtask

   // mostly short jobs, some finished on arrival, some longer ones
   task automatic add_random_arrival();
      logic [15:0] burst;
      logic [7:0]  prio;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         burst = 16'd0;
      else if (pick == 1)
         burst = 16'($urandom_range(7, 255));
      else
         burst = 16'($urandom_range(1, 6));
      // narrow priority range now and then to force ties
      if ($urandom_range(0, 1))
         prio = 8'($urandom_range(0, 3));
      else
         prio = 8'($urandom);
      add_arrival(8'($urandom), burst, prio);
   endtask

   // driver: bursts of items separated by random gaps
   sched_item_type drive_item;
   int             burst_left = 0;
   int             gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            results_due.push_back(schedule_step(drive_item));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (sched_items.size() > 0) begin
               drive_item = sched_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= drive_item.func;
               req_tdata  <= {drive_item.prio, drive_item.burst, drive_item.proc_id};
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 30);
                  gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result item, receiver stalls follow a mode pattern
   int               stall_mode = 0;
   int               mode_cycles = 0;
   int               cycle_count = 0;
   pps_pkg::rsp_type got;
   pps_pkg::rsp_type want;

   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = pps_pkg::rsp_type'(rsp_tdata);
            if (results_due.size() == 0) begin
               $error("result item with nothing expected: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = results_due.pop_front();
               if (got.ran !== want.ran) begin
                  $error("ran expected %0d actual %0d", want.ran, got.ran);
                  mismatch_count++;
               end
               if (got.run_id !== want.run_id) begin
                  $error("run_id expected %0d actual %0d", want.run_id, got.run_id);
                  mismatch_count++;
               end
               if (got.dispatched !== want.dispatched) begin
                  $error("dispatched expected %0d actual %0d",
                         want.dispatched, got.dispatched);
                  mismatch_count++;
               end
               if (got.queued !== want.queued) begin
                  $error("queued expected %0d actual %0d", want.queued, got.queued);
                  mismatch_count++;
               end
               if (got.wait_total !== want.wait_total) begin
                  $error("wait_total expected %0d actual %0d",
                         want.wait_total, got.wait_total);
                  mismatch_count++;
               end
               if (got.dropped !== want.dropped) begin
                  $error("dropped expected %0d actual %0d", want.dropped, got.dropped);
                  mismatch_count++;
               end
            end
         end
         // pick a new stall mode every so often
         if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(0, 3);
            mode_cycles = $urandom_range(20, 120);
         end else begin
            mode_cycles--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= (cycle_count % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // stimulus and end of run
   initial begin
      int count;
      int n;
      int phase;
      // tick on an empty queue
      add_tick();
      // arrival into empty queue, then preemption at the head
      add_arrival(8'h00, 16'd2, 8'h00);
      add_arrival(8'hFF, 16'd1, 8'hFF);
      // equal priority with zero burst lands behind
      add_arrival(8'h11, 16'd0, 8'hFF);
      add_tick();
      add_tick();
      add_tick();
      // queue empties while finished entries are removed
      add_tick();
      // fill the queue, with ties and preemptions
      for (int k = 0; k < QUEUE_DEPTH; k++)
         add_arrival(8'(8'h30 + k), 16'(1 + (k % 3)), 8'((k * 37) % 5));
      // arrival into a full queue
      add_arrival(8'h5A, 16'hFFFF, 8'hFF);

      count = 0;
      while (count < RANDOM_ITEMS) begin
         phase = $urandom_range(0, 2);
         if (phase == 0) begin
            // fill: mostly arrivals, pushes the queue toward full
            n = $urandom_range(8, 24);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 4) == 0)
                  add_tick();
               else
                  add_random_arrival();
            end
         end else if (phase == 1) begin
            // drain: ticks only
            n = $urandom_range(5, 40);
            for (int k = 0; k < n; k++)
               add_tick();
         end else begin
            n = $urandom_range(10, 40);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 1))
                  add_tick();
               else
                  add_random_arrival();
            end
         end
         count += n;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (sched_items.size() != 0 || req_tvalid)
         @(posedge clock);
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
